[rtl/gsht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsht_pkg
// Shared types and constants of the generational handle slot table.
// ----------------------------------------------------------------------------
package gsht_pkg;

  // Default table depth
  localparam int unsigned SLOTS_DEF = 16;

  // Field widths
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  // Stream widths
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_DATA_W = 48;

  // Request kinds
  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_VALIDATE = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_COUNT    = 2'd3
  } gsht_op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } gsht_status_e;

  // One table entry
  typedef struct packed {
    logic             used;
    logic [GEN_W-1:0] gen;
  } gsht_ent_t;

  // Write port of the entry store
  typedef struct packed {
    logic      en;
    gsht_ent_t ent;
  } gsht_wr_t;

  // One result
  typedef struct packed {
    gsht_status_e        status;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  used_count;
  } gsht_res_t;

endpackage
`default_nettype wire

[rtl/generational_handle_slot_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_slot_table
// Hands out 32-bit generational handles from a table of SLOTS slots.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on the s_axis channel: tuser carries the operation
//   (allocate, validate, release, count) and tdata the handle. One result
//   per request leaves on the m_axis channel with status, new handle, slot
//   index and the number of used slots after the request.
//   Path from acceptance to the result in the output register:
//   count and rejected handles go straight to DONE; validate and release
//   pass LOOK_RD and LOOK_CHK; allocate passes ALLOC_RD and ALLOC_CHK for
//   each slot probed by the scan from the lowest possibly free slot.
//   The scan and the handle check share the single read port of the entry
//   memory, so one request is in flight at a time; tready is low from
//   acceptance until its result is handed to the output register.
//   After reset the entry memory is cleared one entry a cycle, with tready
//   low. A stalled receiver holds the output register; the next request
//   may be accepted meanwhile and its result waits.
// ----------------------------------------------------------------------------
module generational_handle_slot_table
  import gsht_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [31:0] handle_in
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [S_USER_W-1:0] s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [1:0] status, [33:2] handle_out, [37:34] slot_index,
  // [42:38] used_count, [47:43] zero
  output logic [M_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic          res_valid;
  logic          res_ready;
  gsht_res_t     res;
  logic [IW-1:0] mem_addr;
  gsht_wr_t      mem_wr;
  gsht_ent_t     mem_rd;

  logic                m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;

  gsht_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_op_i     (s_axis_tuser),
    .req_handle_i (s_axis_tdata[HANDLE_W-1:0]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .addr_o       (mem_addr),
    .wr_o         (mem_wr),
    .rd_i         (mem_rd)
  );

  gsht_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i  (clk_i),
    .addr_i (mem_addr),
    .wr_i   (mem_wr),
    .rd_o   (mem_rd)
  );

  // Output register takes a result when empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  // Pack the result fields, lowest first
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= {5'b00000, res.used_count, res.slot, res.handle, res.status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

[rtl/gsht_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsht_store
// Entry memory: one used flag and one generation per slot, one write port
// and one registered read port sharing the sequencer's address.
// ----------------------------------------------------------------------------
module gsht_store
  import gsht_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic [IW-1:0] addr_i,
  input  wire gsht_wr_t      wr_i,
  output gsht_ent_t          rd_o
);

  gsht_ent_t mem [SLOTS];
  gsht_ent_t rd_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[addr_i] <= wr_i.ent;
    end
  end

  // Read the addressed entry, registered
  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr_i];
  end

  assign rd_o = rd_q;

endmodule
`default_nettype wire

[rtl/gsht_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsht_seq
// Request sequencer: clears the store after reset, scans for the lowest
// free slot, checks handles and updates the used count and free hint.
// ----------------------------------------------------------------------------
module gsht_seq
  import gsht_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned CW   = $clog2(SLOTS + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request side
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire logic [S_USER_W-1:0] req_op_i,
  input  wire logic [HANDLE_W-1:0] req_handle_i,
  // result side
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output gsht_res_t                res_o,
  // entry store
  output logic [IW-1:0]            addr_o,
  output gsht_wr_t                 wr_o,
  input  wire gsht_ent_t           rd_i
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    ALLOC_RD,
    ALLOC_CHK,
    LOOK_RD,
    LOOK_CHK,
    DONE
  } state_e;

  localparam logic [IW-1:0]    LastIdx = IW'(SLOTS - 1);
  localparam logic [CW-1:0]    CntFull = CW'(SLOTS);
  localparam logic [GEN_W-1:0] SlotsW  = GEN_W'(SLOTS);

  state_e              state_q, state_d;
  logic [IW-1:0]       addr_q, addr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       lw_q, lw_d;
  gsht_op_e            op_q, op_d;
  logic [GEN_W-1:0]    gen_q, gen_d;
  gsht_status_e        st_q, st_d;
  logic [HANDLE_W-1:0] hdl_q, hdl_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;

  gsht_op_e            req_op;
  logic [GEN_W-1:0]    hlow;
  logic [GEN_W-1:0]    hidx;
  logic [GEN_W-1:0]    gen_inc;
  logic [GEN_W-1:0]    gen_new;
  logic [IW+3:0]       slot_ext;
  logic [CW+4:0]       cnt_ext;

  assign req_op   = gsht_op_e'(req_op_i);
  assign hlow     = req_handle_i[GEN_W-1:0];
  assign hidx     = hlow - GEN_W'(1);
  assign gen_inc  = rd_i.gen + GEN_W'(1);
  // skip generation zero on wrap
  assign gen_new  = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign slot_ext = {4'b0000, addr_q};
  assign cnt_ext  = {5'b00000, cnt_q};

  // Next-state and datapath control
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    lw_d    = lw_q;
    op_d    = op_q;
    gen_d   = gen_q;
    st_d    = st_q;
    hdl_d   = hdl_q;
    slot_d  = slot_q;
    wr_o    = '0;

    case (state_q)
      CLEAR: begin
        // zero one entry a cycle
        wr_o.en = 1'b1;
        if (addr_q == LastIdx) begin
          addr_d  = '0;
          state_d = IDLE;
        end else begin
          addr_d = addr_q + IW'(1);
        end
      end

      IDLE: begin
        if (req_valid_i) begin
          op_d   = req_op;
          gen_d  = req_handle_i[HANDLE_W-1:GEN_W];
          st_d   = ST_OK;
          hdl_d  = '0;
          slot_d = '0;
          case (req_op)
            OP_ALLOC: begin
              if (cnt_q == CntFull) begin
                st_d    = ST_FULL;
                state_d = DONE;
              end else begin
                addr_d  = lw_q[IW-1:0];
                state_d = ALLOC_RD;
              end
            end
            OP_VALIDATE, OP_RELEASE: begin
              if (hlow == '0 || hlow > SlotsW) begin
                st_d    = ST_INVALID;
                state_d = DONE;
              end else begin
                addr_d  = hidx[IW-1:0];
                state_d = LOOK_RD;
              end
            end
            default: begin
              state_d = DONE;
            end
          endcase
        end
      end

      ALLOC_RD: begin
        state_d = ALLOC_CHK;
      end

      ALLOC_CHK: begin
        if (rd_i.used) begin
          // advance to the next slot
          addr_d  = addr_q + IW'(1);
          state_d = ALLOC_RD;
        end else begin
          wr_o.en       = 1'b1;
          wr_o.ent.used = 1'b1;
          wr_o.ent.gen  = gen_new;
          cnt_d   = cnt_q + CW'(1);
          lw_d    = CW'(addr_q) + CW'(1);
          hdl_d   = {gen_new, GEN_W'(addr_q) + GEN_W'(1)};
          slot_d  = slot_ext[SLOT_W-1:0];
          state_d = DONE;
        end
      end

      LOOK_RD: begin
        state_d = LOOK_CHK;
      end

      LOOK_CHK: begin
        if (rd_i.used && rd_i.gen == gen_q) begin
          slot_d = slot_ext[SLOT_W-1:0];
          if (op_q == OP_RELEASE) begin
            // free the slot, keep its generation
            wr_o.en       = 1'b1;
            wr_o.ent.used = 1'b0;
            wr_o.ent.gen  = rd_i.gen;
            cnt_d = cnt_q - CW'(1);
            if (CW'(addr_q) < lw_q) begin
              lw_d = CW'(addr_q);
            end
          end
        end else begin
          st_d = ST_INVALID;
        end
        state_d = DONE;
      end

      DONE: begin
        if (res_ready_i) begin
          state_d = IDLE;
        end
      end

      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // State, control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLEAR;
      addr_q  <= '0;
      cnt_q   <= '0;
      lw_q    <= '0;
      op_q    <= OP_COUNT;
      gen_q   <= '0;
      st_q    <= ST_OK;
      hdl_q   <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      lw_q    <= lw_d;
      op_q    <= op_d;
      gen_q   <= gen_d;
      st_q    <= st_d;
      hdl_q   <= hdl_d;
      slot_q  <= slot_d;
    end
  end

  assign req_ready_o       = (state_q == IDLE);
  assign res_valid_o       = (state_q == DONE);
  assign res_o.status      = st_q;
  assign res_o.handle      = hdl_q;
  assign res_o.slot        = slot_q;
  assign res_o.used_count  = cnt_ext[COUNT_W-1:0];
  assign addr_o            = addr_q;

endmodule
`default_nettype wire

[test/generational_handle_slot_table_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_slot_table_test
// Self-checking stream test of the generational handle slot table.
// Directed requests cover the empty table, a full table and stale and
// out-of-range handles; random churn then mixes live, retired and noise
// handles with random idling on both stream sides.
// ----------------------------------------------------------------------------
module generational_handle_slot_table_test
  import gsht_pkg::*;
();

  localparam int unsigned NSLOT = SLOTS_DEF;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [31:0] handle_in
  logic [S_DATA_W-1:0] s_axis_tdata;
  // [1:0] operation
  logic [S_USER_W-1:0] s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [1:0] status, [33:2] handle_out, [37:34] slot_index,
  // [42:38] used_count, [47:43] zero
  logic [M_DATA_W-1:0] m_axis_tdata;

  // Shadow of the slot table, updated when a request is accepted
  logic              slot_live [NSLOT];
  logic [GEN_W-1:0]  slot_gen  [NSLOT];
  logic [HANDLE_W-1:0] retired_handles[$];
  gsht_res_t         pending_outcomes[$];

  int unsigned mismatch_count;
  bit          sender_idle_on;
  bit          stall_on;
  int          stall_left;

  generational_handle_slot_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one request to the shadow table and return its outcome
  function automatic gsht_res_t table_outcome(gsht_op_e op, logic [HANDLE_W-1:0] h);
    gsht_res_t        res;
    logic [GEN_W-1:0] g;
    int               idx;
    int               n;
    res = '0;
    res.status = ST_OK;
    idx = -1;
    n = 0;
    case (op)
      OP_ALLOC: begin
        for (int i = NSLOT - 1; i >= 0; i--) if (!slot_live[i]) idx = i;
        if (idx < 0) begin
          res.status = ST_FULL;
        end else begin
          // skip generation 0 on wrap
          g = slot_gen[idx] + 16'd1;
          if (g == '0) g = 16'd1;
          slot_gen[idx] = g;
          slot_live[idx] = 1'b1;
          res.handle = {g, 16'(idx + 1)};
          res.slot = SLOT_W'(idx);
        end
      end
      OP_VALIDATE, OP_RELEASE: begin
        idx = int'(h[15:0]) - 1;
        if (h[15:0] == '0 || h[15:0] > NSLOT || !slot_live[idx] ||
            slot_gen[idx] != h[31:16]) begin
          res.status = ST_INVALID;
        end else begin
          if (op == OP_RELEASE) begin
            slot_live[idx] = 1'b0;
            retired_handles.push_back(h);
            if (retired_handles.size() > 32) void'(retired_handles.pop_front());
          end
          res.slot = SLOT_W'(idx);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NSLOT; i++) if (slot_live[i]) n++;
    res.used_count = COUNT_W'(n);
    return res;
  endfunction

  // Handle for a random request: live, retired, stale or plain noise
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int r;
    int s;
    int j;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, NSLOT - 1);
    if (r < 55) begin
      for (int k = 0; k < NSLOT; k++) begin
        j = (s + k) % NSLOT;
        if (slot_live[j]) return {slot_gen[j], 16'(j + 1)};
      end
    end else if (r < 70 && retired_handles.size() != 0) begin
      return retired_handles[$urandom_range(0, retired_handles.size() - 1)];
    end else if (r < 82) begin
      return {slot_gen[s] + 16'($urandom_range(1, 16'hFFFF)), 16'(s + 1)};
    end else if (r < 90) begin
      return {16'($urandom), 16'($urandom_range(1, NSLOT))};
    end
    return $urandom;
  endfunction

  task automatic report_mismatch(input string field, input logic [M_DATA_W-1:0] want,
                                 input logic [M_DATA_W-1:0] got);
    $display("%0t ns: mismatch on %s: want %0h got %0h", $time, field, want, got);
    mismatch_count++;
  endtask

  // Present one request, wait for acceptance and record its outcome
  task automatic send_request(input gsht_op_e op, input logic [HANDLE_W-1:0] h);
    int gap;
    gap = sender_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_outcomes.push_back(table_outcome(op, h));
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest outstanding outcome
  always @(posedge clk_i) begin : check_result
    gsht_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, m_axis_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tdata[1:0] != want.status)
          report_mismatch("status", M_DATA_W'(want.status),
                          M_DATA_W'(m_axis_tdata[1:0]));
        if (m_axis_tdata[33:2] != want.handle)
          report_mismatch("handle_out", M_DATA_W'(want.handle),
                          M_DATA_W'(m_axis_tdata[33:2]));
        if (m_axis_tdata[37:34] != want.slot)
          report_mismatch("slot_index", M_DATA_W'(want.slot),
                          M_DATA_W'(m_axis_tdata[37:34]));
        if (m_axis_tdata[42:38] != want.used_count)
          report_mismatch("used_count", M_DATA_W'(want.used_count),
                          M_DATA_W'(m_axis_tdata[42:38]));
        if (m_axis_tdata[47:43] != '0)
          report_mismatch("padding", '0, M_DATA_W'(m_axis_tdata[47:43]));
      end
    end
  end

  // Empty table: count, zero, out-of-range and never-allocated handles
  task automatic test_empty_table();
    send_request(OP_COUNT, $urandom);
    send_request(OP_VALIDATE, 32'h0000_0000);
    send_request(OP_RELEASE, 32'h0001_0011);
    send_request(OP_VALIDATE, 32'h0000_0001);
    send_request(OP_VALIDATE, 32'hFFFF_FFFF);
    wait_results_drained();
  endtask

  // Fill every slot, then one allocate too many
  task automatic test_fill_to_full();
    repeat (NSLOT + 1) send_request(OP_ALLOC, $urandom);
    wait_results_drained();
  endtask

  // Generation mismatch, generation zero, release and reuse of a slot
  task automatic test_stale_handles();
    send_request(OP_VALIDATE, 32'h0001_0001);
    send_request(OP_VALIDATE, 32'h0002_0001);
    send_request(OP_VALIDATE, 32'h0000_0001);
    send_request(OP_RELEASE, 32'h0001_0010);
    send_request(OP_VALIDATE, 32'h0001_0010);
    send_request(OP_RELEASE, 32'h0001_0010);
    send_request(OP_ALLOC, $urandom);
    send_request(OP_VALIDATE, 32'h0002_0010);
    wait_results_drained();
  endtask

  // Random churn with a given mix of allocates and releases
  task automatic test_random_churn(input int n_req, input int alloc_pct,
                                   input int release_pct, input bit idle, input bit stall);
    int       r;
    gsht_op_e op;
    sender_idle_on = idle;
    stall_on = stall;
    for (int k = 0; k < n_req; k++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) op = OP_ALLOC;
      else if (r < alloc_pct + release_pct) op = OP_RELEASE;
      else if (r < 94) op = OP_VALIDATE;
      else op = OP_COUNT;
      send_request(op, pick_handle());
      if ($urandom_range(0, 99) == 0) wait_results_drained();
    end
    wait_results_drained();
  endtask

  // Reset, tests in turn, verdict
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_COUNT;
    m_axis_tready = 1'b0;
    stall_left = 0;
    mismatch_count = 0;
    sender_idle_on = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < NSLOT; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_fill_to_full();
    test_stale_handles();
    test_random_churn(350, 60, 15, 1'b1, 1'b1);
    test_random_churn(300, 15, 60, 1'b0, 1'b0);
    test_random_churn(350, 35, 35, 1'b1, 1'b1);
    test_random_churn(300, 40, 30, 1'b0, 1'b1);

    // let any stray result show up
    s_axis_tvalid <= 1'b0;
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard time limit
  initial begin
    #80_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
